FILE: hw/rtl/htlp_pkg.sv
`timescale 1ns / 1ps

package htlp_pkg;

  // Field widths of the transactions
  localparam int unsigned KEY_W   = 30;
  localparam int unsigned PAY_W   = 32;
  localparam int unsigned SLOT_W  = 10;
  localparam int unsigned PROBE_W = 10;

  // Opcodes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // Result status codes
  localparam logic [1:0] STATUS_INSERTED  = 2'd0;
  localparam logic [1:0] STATUS_FOUND     = 2'd1;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
  localparam logic [1:0] STATUS_FULL      = 2'd3;

  // One table slot as held in memory
  typedef struct packed {
    logic             occ;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] pay;
  } entry_t;

endpackage

FILE: hw/rtl/htlp_hash.sv
`timescale 1ns / 1ps

module htlp_hash #(
  parameter int unsigned TABLE_SIZE = 631
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [htlp_pkg::KEY_W-1:0]        key_i,
  output logic                              done_o,
  output logic [$clog2(TABLE_SIZE)-1:0]     home_o
);
  import htlp_pkg::*;

  localparam int unsigned IW    = $clog2(TABLE_SIZE);
  localparam int unsigned Shift = KEY_W + IW;
  localparam int unsigned ProdW = KEY_W + 32;
  // ceil(2^Shift / TABLE_SIZE) gives the exact quotient for every key width value
  localparam logic [63:0] RecipWide =
    ((64'd1 << Shift) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE);
  localparam logic [31:0]      Recip = 32'(RecipWide);
  localparam logic [KEY_W-1:0] TsKey = KEY_W'(TABLE_SIZE);

  logic             mul_vld_q;
  logic             sub_vld_q;
  logic             done_q;
  logic [KEY_W-1:0] key_q;
  logic [KEY_W-1:0] quot_q;
  logic [KEY_W-1:0] quot_d;
  logic [ProdW-1:0] prod;
  logic [KEY_W-1:0] back;
  logic [KEY_W-1:0] diff;
  logic [IW-1:0]    rem_q;

  // Quotient by reciprocal multiplication, remainder by multiply-subtract
  assign prod   = ProdW'(key_q) * ProdW'(Recip);
  assign quot_d = KEY_W'(prod >> Shift);
  assign back   = quot_q * TsKey;
  assign diff   = key_q - back;

  // Advance the two stages of the reduction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_vld_q <= 1'b0;
      sub_vld_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      mul_vld_q <= start_i;
      sub_vld_q <= mul_vld_q;
      done_q    <= sub_vld_q;
    end
  end

  // Hold the key, the quotient and the remainder
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      key_q <= key_i;
    end
    if (mul_vld_q) begin
      quot_q <= quot_d;
    end
    if (sub_vld_q) begin
      rem_q <= diff[IW-1:0];
    end
  end

  assign done_o = done_q;
  assign home_o = rem_q;

endmodule

FILE: hw/rtl/htlp_mem.sv
`timescale 1ns / 1ps

module htlp_mem #(
  parameter int unsigned DEPTH = 631
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [$clog2(DEPTH)-1:0]      waddr_i,
  input  htlp_pkg::entry_t              wdata_i,
  input  logic                          re_i,
  input  logic [$clog2(DEPTH)-1:0]      raddr_i,
  output htlp_pkg::entry_t              rdata_o
);
  import htlp_pkg::*;

  entry_t mem_q [DEPTH];
  entry_t rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/htlp_ctrl.sv
`timescale 1ns / 1ps

module htlp_ctrl #(
  parameter int unsigned TABLE_SIZE = 631
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                opcode_i,
  input  logic [htlp_pkg::KEY_W-1:0]          key_i,
  input  logic [htlp_pkg::PAY_W-1:0]          payload_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [1:0]                          status_o,
  output logic [htlp_pkg::SLOT_W-1:0]         slot_o,
  output logic [htlp_pkg::PAY_W-1:0]          found_payload_o,
  output logic [htlp_pkg::PROBE_W-1:0]        probes_o,
  // remainder unit
  output logic                                hash_start_o,
  input  logic                                hash_done_i,
  input  logic [$clog2(TABLE_SIZE)-1:0]       hash_home_i,
  // table memory
  output logic                                mem_we_o,
  output logic [$clog2(TABLE_SIZE)-1:0]       mem_waddr_o,
  output htlp_pkg::entry_t                    mem_wdata_o,
  output logic                                mem_re_o,
  output logic [$clog2(TABLE_SIZE)-1:0]       mem_raddr_o,
  input  htlp_pkg::entry_t                    mem_rdata_i
);
  import htlp_pkg::*;

  localparam int unsigned IW = $clog2(TABLE_SIZE);
  localparam int unsigned CW = $clog2(TABLE_SIZE + 1);
  localparam logic [IW-1:0] LastSlot = IW'(TABLE_SIZE - 1);
  localparam logic [CW-1:0] AllProbes = CW'(TABLE_SIZE);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_HASH  = 2'd2;
  localparam logic [1:0] ST_PROBE = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [IW-1:0]    clr_q;
  logic [IW-1:0]    pos_q, pos_d;
  logic [IW-1:0]    pos_inc;
  logic [IW-1:0]    home_q;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             op_q;
  logic [KEY_W-1:0] key_q;
  logic [PAY_W-1:0] pay_q;

  logic             accept;
  logic             finish;
  logic             advance;
  logic             out_free;
  logic             load;
  logic [1:0]       res_status;
  logic [IW-1:0]    res_slot;
  logic [PAY_W-1:0] res_pay;

  logic                   out_valid_q, out_valid_d;
  logic [1:0]             status_q;
  logic [SLOT_W-1:0]      slot_q;
  logic [PAY_W-1:0]       fpay_q;
  logic [PROBE_W-1:0]     probes_q;
  logic [IW+SLOT_W-1:0]   slot_ext;
  logic [CW+PROBE_W-1:0]  cnt_ext;

  assign in_stall_o   = (state_q != ST_IDLE);
  assign accept       = in_valid_i && !in_stall_o;
  assign hash_start_o = accept;
  assign pos_inc      = (pos_q == LastSlot) ? '0 : pos_q + 1'b1;
  assign out_free     = !out_valid_q || !out_stall_i;

  // Evaluate the slot read back for the current probe
  always_comb begin
    finish     = 1'b0;
    res_status = STATUS_NOT_FOUND;
    res_slot   = home_q;
    res_pay    = '0;
    if (op_q == OP_INSERT && !mem_rdata_i.occ) begin
      finish     = 1'b1;
      res_status = STATUS_INSERTED;
      res_slot   = pos_q;
    end else if (op_q == OP_SEARCH && !mem_rdata_i.occ) begin
      finish     = 1'b1;
    end else if (op_q == OP_SEARCH && mem_rdata_i.key == key_q) begin
      finish     = 1'b1;
      res_status = STATUS_FOUND;
      res_slot   = pos_q;
      res_pay    = mem_rdata_i.pay;
    end else if (cnt_q == AllProbes) begin
      finish     = 1'b1;
      res_status = (op_q == OP_INSERT) ? STATUS_FULL : STATUS_NOT_FOUND;
    end
  end

  assign load    = (state_q == ST_PROBE) && finish && out_free;
  assign advance = (state_q == ST_PROBE) && !finish;

  // Next state, probe position and probe count
  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == LastSlot) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_HASH;
        end
      end
      ST_HASH: begin
        if (hash_done_i) begin
          state_d = ST_PROBE;
          pos_d   = hash_home_i;
          cnt_d   = CW'(1);
        end
      end
      ST_PROBE: begin
        if (load) begin
          state_d = ST_IDLE;
        end else if (advance) begin
          pos_d = pos_inc;
          cnt_d = cnt_q + 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
    end
  end

  // Transaction and probe bookkeeping
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= opcode_i;
      key_q <= key_i;
      pay_q <= payload_i;
    end
    if (state_q == ST_HASH && hash_done_i) begin
      home_q <= hash_home_i;
    end
    pos_q <= pos_d;
    cnt_q <= cnt_d;
  end

  // Read at home once hashed, then one slot up per cycle
  assign mem_re_o    = (state_q == ST_HASH && hash_done_i) || advance;
  assign mem_raddr_o = (state_q == ST_HASH) ? hash_home_i : pos_inc;

  // Clear the occupied flags after reset; store the record on insert
  always_comb begin
    mem_we_o    = 1'b0;
    mem_waddr_o = pos_q;
    mem_wdata_o = '0;
    if (state_q == ST_CLEAR) begin
      mem_we_o    = 1'b1;
      mem_waddr_o = clr_q;
    end else if (load && res_status == STATUS_INSERTED) begin
      mem_we_o        = 1'b1;
      mem_wdata_o.occ = 1'b1;
      mem_wdata_o.key = key_q;
      mem_wdata_o.pay = pay_q;
    end
  end

  // Result register: take a new result when empty or being drained
  assign slot_ext = {{SLOT_W{1'b0}}, res_slot};
  assign cnt_ext  = {{PROBE_W{1'b0}}, cnt_q};

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      status_q <= res_status;
      slot_q   <= slot_ext[SLOT_W-1:0];
      fpay_q   <= res_pay;
      probes_q <= cnt_ext[PROBE_W-1:0];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign slot_o          = slot_q;
  assign found_payload_o = fpay_q;
  assign probes_o        = probes_q;

endmodule

FILE: hw/rtl/hash_table_division_linear_probe_top.sv
`timescale 1ns / 1ps
// Open-addressing hash table, home slot = key mod TABLE_SIZE, linear probing.
// Input channel (in_valid_i / in_stall_o) carries one transaction per
// operation: opcode 0 inserts key and payload in the first free slot from
// home, opcode 1 searches for key. Each transaction gives exactly one result
// on the output channel (out_valid_o / out_stall_i): status, slot, payload
// of the match and the number of slots probed.
// The remainder unit registers the key, the quotient (reciprocal multiply)
// and the remainder (multiply-subtract); then the single read port of the
// table memory probes one slot per cycle. One item is processed at a time:
// in_stall_o stays high from acceptance until its result is loaded into
// the output register.
// After reset the block sweeps all TABLE_SIZE slots of the table memory
// to clear every occupied flag; in_stall_o stays high during that sweep.
// A finished result sits in an output register, so a new transaction is
// accepted while the receiver stalls; a second result waits in the probe
// stage until the output register is taken.
module hash_table_division_linear_probe_top #(
  parameter int unsigned TABLE_SIZE = 631
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          opcode_i,
  input  logic [htlp_pkg::KEY_W-1:0]    key_i,
  input  logic [htlp_pkg::PAY_W-1:0]    payload_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    status_o,
  output logic [htlp_pkg::SLOT_W-1:0]   slot_o,
  output logic [htlp_pkg::PAY_W-1:0]    found_payload_o,
  output logic [htlp_pkg::PROBE_W-1:0]  probes_o
);
  import htlp_pkg::*;

  localparam int unsigned IW = $clog2(TABLE_SIZE);

  logic          hash_start;
  logic          hash_done;
  logic [IW-1:0] hash_home;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic          mem_re;
  logic [IW-1:0] mem_raddr;
  entry_t        mem_rdata;

  htlp_hash #(
    .TABLE_SIZE(TABLE_SIZE)
  ) u_hash (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(hash_start),
    .key_i  (key_i),
    .done_o (hash_done),
    .home_o (hash_home)
  );

  htlp_mem #(
    .DEPTH(TABLE_SIZE)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  htlp_ctrl #(
    .TABLE_SIZE(TABLE_SIZE)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .key_i          (key_i),
    .payload_i      (payload_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .slot_o         (slot_o),
    .found_payload_o(found_payload_o),
    .probes_o       (probes_o),
    .hash_start_o   (hash_start),
    .hash_done_i    (hash_done),
    .hash_home_i    (hash_home),
    .mem_we_o       (mem_we),
    .mem_waddr_o    (mem_waddr),
    .mem_wdata_o    (mem_wdata),
    .mem_re_o       (mem_re),
    .mem_raddr_o    (mem_raddr),
    .mem_rdata_i    (mem_rdata)
  );

endmodule

FILE: tb/htlp_result_checker.sv
`timescale 1ns / 1ps

module htlp_result_checker #(
  parameter int unsigned TABLE_SIZE = 631
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic                          opcode_i,
  input  logic [htlp_pkg::KEY_W-1:0]    key_i,
  input  logic [htlp_pkg::PAY_W-1:0]    payload_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [1:0]                    status_i,
  input  logic [htlp_pkg::SLOT_W-1:0]   slot_i,
  input  logic [htlp_pkg::PAY_W-1:0]    found_payload_i,
  input  logic [htlp_pkg::PROBE_W-1:0]  probes_i,
  output int unsigned                   pending_o,
  output int unsigned                   fails_o
);
  import htlp_pkg::*;

  typedef struct packed {
    logic [1:0]         status;
    logic [SLOT_W-1:0]  slot;
    logic [PAY_W-1:0]   pay;
    logic [PROBE_W-1:0] probes;
  } table_outcome_t;

  // Mirror of the table contents
  bit             occ_mirror [TABLE_SIZE];
  bit [KEY_W-1:0] key_mirror [TABLE_SIZE];
  bit [PAY_W-1:0] pay_mirror [TABLE_SIZE];

  table_outcome_t outcomes_due[$];
  table_outcome_t want;
  table_outcome_t next_outcome;
  int unsigned    errors;

  // Walk the mirror from the home slot exactly as the table is probed
  task automatic walk_table(input logic op, input logic [KEY_W-1:0] k,
                            input logic [PAY_W-1:0] p, output table_outcome_t res);
    int unsigned home;
    int unsigned pos;
    int unsigned n;
    bit          done;
    home = 32'(k) % TABLE_SIZE;
    pos  = home;
    done = 1'b0;
    // Fall-through result when every slot has been examined
    res.status = (op == OP_INSERT) ? STATUS_FULL : STATUS_NOT_FOUND;
    res.slot   = SLOT_W'(home);
    res.pay    = '0;
    res.probes = PROBE_W'(TABLE_SIZE);
    for (n = 1; n <= TABLE_SIZE && !done; n++) begin
      if (!occ_mirror[pos]) begin
        if (op == OP_INSERT) begin
          occ_mirror[pos] = 1'b1;
          key_mirror[pos] = k;
          pay_mirror[pos] = p;
          res = '{STATUS_INSERTED, SLOT_W'(pos), '0, PROBE_W'(n)};
        end else begin
          res = '{STATUS_NOT_FOUND, SLOT_W'(home), '0, PROBE_W'(n)};
        end
        done = 1'b1;
      end else if (op == OP_SEARCH && key_mirror[pos] == k) begin
        res  = '{STATUS_FOUND, SLOT_W'(pos), pay_mirror[pos], PROBE_W'(n)};
        done = 1'b1;
      end
      if (!done) pos = (pos == TABLE_SIZE - 1) ? 0 : pos + 1;
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_val,
                             input logic [31:0] act_val);
    if (act_val !== exp_val) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_val, act_val);
      errors++;
    end
  endtask

  // Compare results first: a result never belongs to a transaction taken at the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TABLE_SIZE; i++) occ_mirror[i] = 1'b0;
      outcomes_due.delete();
      errors = 0;
      pending_o <= 0;
      fails_o   <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (outcomes_due.size() == 0) begin
          $display("%0t: unexpected result, status %0d slot %0d payload %0h probes %0d",
                   $time, status_i, slot_i, found_payload_i, probes_i);
          errors++;
        end else begin
          want = outcomes_due.pop_front();
          check_field("status", 32'(want.status), 32'(status_i));
          check_field("slot", 32'(want.slot), 32'(slot_i));
          check_field("found_payload", want.pay, found_payload_i);
          check_field("probes", 32'(want.probes), 32'(probes_i));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        walk_table(opcode_i, key_i, payload_i, next_outcome);
        outcomes_due.push_back(next_outcome);
      end
      pending_o <= outcomes_due.size();
      fails_o   <= errors;
    end
  end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import htlp_pkg::*;

  localparam int unsigned TABLE_SIZE   = 631;
  localparam int unsigned RANDOM_ITEMS = 1400;
  localparam int unsigned LONG_HOLD    = 300;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic               opcode;
  logic [KEY_W-1:0]   key;
  logic [PAY_W-1:0]   payload;
  logic               out_valid;
  logic               out_stall;
  logic [1:0]         status;
  logic [SLOT_W-1:0]  slot;
  logic [PAY_W-1:0]   found_payload;
  logic [PROBE_W-1:0] probes;
  int unsigned        pending;
  int unsigned        fails;

  // Stimulus bookkeeping
  logic [KEY_W-1:0] placed_keys[$];
  int unsigned      n_inserts;
  int unsigned      n_searches;
  int unsigned      gap_pct;
  bit               quiet;
  bit               hold_go;

  always #1 clk = ~clk;

  hash_table_division_linear_probe_top #(
    .TABLE_SIZE(TABLE_SIZE)
  ) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .opcode_i       (opcode),
    .key_i          (key),
    .payload_i      (payload),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .status_o       (status),
    .slot_o         (slot),
    .found_payload_o(found_payload),
    .probes_o       (probes)
  );

  htlp_result_checker #(
    .TABLE_SIZE(TABLE_SIZE)
  ) u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .opcode_i       (opcode),
    .key_i          (key),
    .payload_i      (payload),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .status_i       (status),
    .slot_i         (slot),
    .found_payload_i(found_payload),
    .probes_i       (probes),
    .pending_o      (pending),
    .fails_o        (fails)
  );

  function automatic int unsigned pick_rate();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 5;
      2: return 20;
      default: return 40;
    endcase
  endfunction

  // Hold the transaction until the block takes it
  task automatic offer(input logic op, input logic [KEY_W-1:0] k, input logic [PAY_W-1:0] p);
    in_valid <= 1'b1;
    opcode   <= op;
    key      <= k;
    payload  <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (op == OP_INSERT) begin
      n_inserts++;
      if (placed_keys.size() < TABLE_SIZE) placed_keys.push_back(k);
    end else begin
      n_searches++;
    end
  endtask

  task automatic maybe_idle();
    if (!quiet && gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // Drop valid and wait until every outstanding result has been taken
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Fresh keys mostly, plus duplicates and keys that share a home slot
  task automatic insert_random();
    logic [KEY_W-1:0] k;
    int unsigned      roll;
    roll = $urandom_range(0, 99);
    if (placed_keys.size() == 0 || roll < 70) begin
      k = KEY_W'($urandom);
    end else if (roll < 85) begin
      k = placed_keys[$urandom_range(0, placed_keys.size() - 1)];
    end else begin
      k = placed_keys[$urandom_range(0, placed_keys.size() - 1)]
          + KEY_W'(TABLE_SIZE * $urandom_range(1, 4));
    end
    offer(OP_INSERT, k, $urandom);
  endtask

  task automatic search_random();
    logic [KEY_W-1:0] k;
    if (placed_keys.size() != 0 && $urandom_range(0, 99) < 60) begin
      k = placed_keys[$urandom_range(0, placed_keys.size() - 1)];
    end else begin
      k = KEY_W'($urandom);
    end
    offer(OP_SEARCH, k, $urandom);
  endtask

  // Output side: random stall bursts, one long hold-off on request
  initial begin : receiver
    bit          hold_done;
    int unsigned stall_pct;
    int unsigned cycles;
    hold_done = 1'b0;
    stall_pct = 0;
    cycles    = 0;
    out_stall <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles % 256 == 0) stall_pct = pick_rate();
      if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Hard stop for a hung block
  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    n_inserts  = 0;
    n_searches = 0;
    gap_pct    = 0;
    quiet      = 1'b0;
    hold_go    = 1'b0;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    opcode   <= OP_INSERT;
    key      <= '0;
    payload  <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty table, collisions at slot 0, wrap from the last slot,
    // duplicates, extreme keys and payloads
    offer(OP_SEARCH, 30'd12345, 32'h0);
    offer(OP_INSERT, 30'd0, 32'h0000_0000);
    offer(OP_INSERT, 30'd631, 32'hFFFF_FFFF);
    offer(OP_INSERT, 30'd630, 32'hA5A5_A5A5);
    offer(OP_INSERT, 30'd1261, 32'h5A5A_5A5A);
    offer(OP_INSERT, 30'd0, 32'h1234_5678);
    offer(OP_SEARCH, 30'd0, 32'hFFFF_FFFF);
    offer(OP_SEARCH, 30'd1261, 32'h0);
    offer(OP_SEARCH, 30'd1892, 32'h0);
    offer(OP_INSERT, 30'h3FFF_FFFF, 32'hFFFF_FFFF);
    offer(OP_SEARCH, 30'h3FFF_FFFF, 32'h0);
    offer(OP_INSERT, 30'd999999999, 32'h8000_0001);
    offer(OP_SEARCH, 30'd999999999, 32'h0);
    offer(OP_INSERT, 30'd1000000000, 32'h7FFF_FFFE);
    offer(OP_SEARCH, 30'd1000000000, 32'h0);
    offer(OP_SEARCH, 30'd631, 32'h0);
    offer(OP_SEARCH, 30'h2AAA_AAAA, 32'h0);
    offer(OP_INSERT, 30'h1555_5555, 32'hAAAA_AAAA);
    offer(OP_SEARCH, 30'h1555_5555, 32'h5555_5555);

    // Random mix; keep the load moderate so searches stay short
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 200 == 0) gap_pct = pick_rate();
      if (i == 400) hold_go = 1'b1;
      if (i == 800) drain();
      if (placed_keys.size() < 560 && $urandom_range(0, 99) < 32) insert_random();
      else search_random();
      maybe_idle();
    end

    // Fill every slot, then push inserts and searches against a full table
    drain();
    quiet = 1'b1;
    while (placed_keys.size() < TABLE_SIZE) insert_random();
    repeat (3) insert_random();
    repeat (3) offer(OP_SEARCH, KEY_W'($urandom), $urandom);
    repeat (3) search_random();

    drain();
    repeat (40) @(posedge clk);
    $display("Covered %0d inserts and %0d searches: collisions, wrap-around, duplicate keys,",
             n_inserts, n_searches);
    $display("back-pressure, and a completely full table with full-length probe walks.");
    if (fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
